// ----- sv/address_region_resolver_top_defines.svh -----
// Assertion macros shared by the address region resolver RTL.
// No dependencies.
`ifndef ADDRESS_REGION_RESOLVER_TOP_DEFINES_SVH
`define ADDRESS_REGION_RESOLVER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ARR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARR_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARR_ASSERT(label, clk, rst_n, prop, msg)
`define ARR_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- sv/arr_pkg.sv -----
// Types and constants for the address region resolver.
// No dependencies.
`default_nettype none
package arr_pkg;
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_INSERT  = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [2:0] KIND_NULL = 3'd0;
    localparam logic [2:0] KIND_USER = 3'd1;
    localparam logic [2:0] KIND_KERNEL = 3'd2;
    localparam logic [2:0] KIND_NONCANON = 3'd3;
    localparam logic [2:0] KIND_POISON = 3'd4;

    localparam logic [1:0] INS_STORED = 2'd0;
    localparam logic [1:0] INS_SKIPPED = 2'd1;
    localparam logic [1:0] INS_FULL = 2'd2;
    localparam logic [1:0] INS_NONE = 2'd3;

    localparam logic [3:0] POISON_NONE = 4'd0;
    localparam logic [3:0] POISON_ONES = 4'd9;

    localparam logic [63:0] NULL_PAGE_LIMIT = 64'h0000_0000_0001_0000;
    localparam logic [63:0] KERNEL_START_NARROW = 64'h0000_0000_8000_0000;
    localparam logic [63:0] USER_LIMIT_WIDE = 64'h0000_8000_0000_0000;
    localparam logic [63:0] KERNEL_START_WIDE = 64'hFFFF_8000_0000_0000;

    localparam logic [31:0] SENTINELS [8] = '{
        32'hCCCCCCCC, 32'hCDCDCDCD, 32'hDDDDDDDD, 32'hFDFDFDFD,
        32'hABABABAB, 32'hBAADF00D, 32'hFEEEFEEE, 32'hDEADBEEF
    };

    function automatic logic [2:0] classify(input logic [63:0] a, input logic narrow);
        logic [2:0] k;
        if (a < NULL_PAGE_LIMIT) begin
            k = KIND_NULL;
        end else if (narrow) begin
            k = (a >= KERNEL_START_NARROW) ? KIND_KERNEL : KIND_USER;
        end else if (a >= KERNEL_START_WIDE) begin
            k = KIND_KERNEL;
        end else if (a < USER_LIMIT_WIDE) begin
            k = KIND_USER;
        end else begin
            k = KIND_NONCANON;
        end
        return k;
    endfunction

    function automatic logic [3:0] poison_of(input logic [63:0] a, input logic narrow);
        logic [3:0] pc;
        pc = POISON_NONE;
        for (int k = 7; k >= 0; k--) begin
            if (a[31:0] == SENTINELS[k] &&
                (narrow || a[63:32] == SENTINELS[k] || a[63:32] == 32'd0)) begin
                pc = 4'(k + 1);
            end
        end
        if (pc == POISON_NONE && (a == '1 || (narrow && a[31:0] == '1))) begin
            pc = POISON_ONES;
        end
        return pc;
    endfunction
endpackage
`default_nettype wire

// ----- sv/address_region_resolver_top.sv -----
// Address region resolver: sorted range table with insert, clear and resolve.
// Depends on arr_pkg and address_region_resolver_top_defines.svh.
// Resolve runs a binary search and then up to PROBE_DEPTH probes, each search step and each probe
// stepping through a read, wait and compare state on one table port.
// Insert runs the same search, then moves entries one at a time (up to TABLE_ENTRIES-1).
// One request at a time. Reset empties the table and clears the mode register to 0.
`default_nettype none
`include "address_region_resolver_top_defines.svh"
module address_region_resolver_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PROBE_DEPTH = 8,
    parameter int ID_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_operation,
    input  wire logic [63:0]  s_address,
    input  wire logic [63:0]  s_range_size,
    input  wire logic [63:0]  s_range_end,
    input  wire logic [15:0]  s_module_id,
    input  wire logic         s_is_unloaded,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_address_kind,
    output logic [3:0]        m_poison_code,
    output logic              m_region_hit,
    output logic              m_hit_unloaded,
    output logic [15:0]       m_hit_id,
    output logic [63:0]       m_hit_base,
    output logic [63:0]       m_hit_offset,
    output logic [1:0]        m_insert_status
);
    import arr_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = $clog2(PROBE_DEPTH + 1);
    localparam int EW = 64 + 64 + ID_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_BS_READ, S_BS_WAIT, S_BS_CMP, S_PR_READ, S_PR_WAIT, S_PR_CMP,
        S_SH_READ, S_SH_WAIT, S_SH_WRITE, S_INS_WRITE, S_OUT
    } state_t;

    logic [EW-1:0] mem [TABLE_ENTRIES];
    logic [EW-1:0] rd_data_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data;

    state_t        state_reg;
    logic          mode_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [CW-1:0] idx_reg;
    logic [PW-1:0] steps_reg;
    logic [1:0]    op_reg;
    logic [63:0]   addr_reg, end_reg;
    logic [ID_BITS-1:0] id_reg;
    logic          unl_reg;
    logic          uhit_reg;
    logic [EW-1:0] uhit_ent_reg;

    logic [63:0]   e_base, e_end;
    logic [ID_BITS-1:0] e_id;
    logic          e_unl;
    logic [CW-1:0] mid;
    logic          go_right;
    logic          covers;
    logic [63:0]   ins_end;
    logic          ins_skip;

    assign e_base = rd_data_reg[EW-1 -: 64];
    assign e_end = rd_data_reg[EW-65 -: 64];
    assign e_id = rd_data_reg[ID_BITS:1];
    assign e_unl = rd_data_reg[0];
    assign mid = CW'((CW+1)'(lo_reg) + (CW+1)'(hi_reg) >> 1);
    assign go_right = (op_reg == OP_INSERT)
        ? (e_base < addr_reg || (e_base == addr_reg && e_id <= id_reg))
        : (e_base <= addr_reg);
    assign covers = addr_reg >= e_base && addr_reg < e_end;
    assign s_ready = (state_reg == S_IDLE) && !m_valid;
    assign cfg_ready = 1'b1;

    always_comb begin
        ins_end = s_range_size + s_address;
        if (s_is_unloaded && s_range_end != 64'd0) begin
            ins_end = s_range_end;
        end
        ins_skip = (s_address == 64'd0) ||
            (s_is_unloaded ? (ins_end <= s_address) : (s_range_size == 64'd0));
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = rd_data_reg;
        rd_addr = mid[IW-1:0];
        unique case (state_reg)
            S_PR_READ, S_PR_WAIT, S_SH_READ, S_SH_WAIT: rd_addr = IW'(idx_reg - CW'(1));
            S_SH_WRITE: wr_en = 1'b1;
            S_INS_WRITE: begin
                wr_en = 1'b1;
                wr_data = {addr_reg, end_reg, id_reg, unl_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg <= 1'b0;
            count_reg <= '0;
            steps_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg <= s_operation;
                        addr_reg <= s_address;
                        end_reg <= ins_end;
                        id_reg <= ID_BITS'(s_module_id);
                        unl_reg <= s_is_unloaded;
                        lo_reg <= '0;
                        hi_reg <= count_reg;
                        uhit_reg <= 1'b0;
                        steps_reg <= '0;
                        m_region_hit <= 1'b0;
                        m_hit_unloaded <= 1'b0;
                        m_hit_id <= '0;
                        m_hit_base <= '0;
                        m_hit_offset <= '0;
                        case (s_operation)
                            OP_INSERT: begin
                                m_address_kind <= KIND_NULL;
                                m_poison_code <= POISON_NONE;
                                if (ins_skip) begin
                                    m_insert_status <= INS_SKIPPED;
                                    state_reg <= S_OUT;
                                end else if (count_reg >= CW'(TABLE_ENTRIES)) begin
                                    m_insert_status <= INS_FULL;
                                    state_reg <= S_OUT;
                                end else begin
                                    m_insert_status <= INS_STORED;
                                    state_reg <= S_BS_READ;
                                end
                            end
                            OP_RESOLVE: begin
                                m_insert_status <= INS_NONE;
                                if (poison_of(s_address, mode_reg) != POISON_NONE) begin
                                    m_address_kind <= KIND_POISON;
                                    m_poison_code <= poison_of(s_address, mode_reg);
                                    state_reg <= S_OUT;
                                end else begin
                                    m_address_kind <= classify(s_address, mode_reg);
                                    m_poison_code <= POISON_NONE;
                                    state_reg <= S_BS_READ;
                                end
                            end
                            default: begin
                                m_address_kind <= KIND_NULL;
                                m_poison_code <= POISON_NONE;
                                m_insert_status <= INS_NONE;
                                state_reg <= S_OUT;
                                if (s_operation == OP_CLEAR) begin
                                    count_reg <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_BS_READ: begin
                    if (lo_reg == hi_reg) begin
                        if (op_reg == OP_INSERT) begin
                            idx_reg <= count_reg;
                            state_reg <= (count_reg == lo_reg) ? S_INS_WRITE : S_SH_READ;
                        end else begin
                            idx_reg <= lo_reg;
                            state_reg <= S_PR_READ;
                        end
                    end else begin
                        state_reg <= S_BS_WAIT;
                    end
                end
                S_BS_WAIT: state_reg <= S_BS_CMP;
                S_BS_CMP: begin
                    if (go_right) begin
                        lo_reg <= mid + CW'(1);
                    end else begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_BS_READ;
                end
                S_PR_READ: begin
                    if (idx_reg == '0 || steps_reg == PW'(PROBE_DEPTH)) begin
                        if (uhit_reg) begin
                            m_region_hit <= 1'b1;
                            m_hit_unloaded <= 1'b1;
                            m_hit_id <= 16'(uhit_ent_reg[ID_BITS:1]);
                            m_hit_base <= uhit_ent_reg[EW-1 -: 64];
                            m_hit_offset <= addr_reg - uhit_ent_reg[EW-1 -: 64];
                        end
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_PR_WAIT;
                    end
                end
                S_PR_WAIT: state_reg <= S_PR_CMP;
                S_PR_CMP: begin
                    idx_reg <= idx_reg - CW'(1);
                    steps_reg <= steps_reg + PW'(1);
                    state_reg <= (covers && !e_unl) ? S_OUT : S_PR_READ;
                    if (covers) begin
                        if (e_unl) begin
                            if (!uhit_reg) begin
                                uhit_reg <= 1'b1;
                                uhit_ent_reg <= rd_data_reg;
                            end
                        end else begin
                            m_region_hit <= 1'b1;
                            m_hit_unloaded <= 1'b0;
                            m_hit_id <= 16'(e_id);
                            m_hit_base <= e_base;
                            m_hit_offset <= addr_reg - e_base;
                        end
                    end
                end
                S_SH_READ: state_reg <= S_SH_WAIT;
                S_SH_WAIT: state_reg <= S_SH_WRITE;
                S_SH_WRITE: begin
                    idx_reg <= idx_reg - CW'(1);
                    state_reg <= (idx_reg - CW'(1) == lo_reg) ? S_INS_WRITE : S_SH_READ;
                end
                S_INS_WRITE: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ARR_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(TABLE_ENTRIES), "count overflow")
    `ARR_ASSERT(a_busy_not_ready, aclk, aresetn, (state_reg != S_IDLE) |-> !s_ready, "ready while busy")
    `ARR_ASSERT(a_out_once, aclk, aresetn, (state_reg == S_OUT) |=> m_valid, "result lost")
    `ARR_ASSERT(a_probe_bound, aclk, aresetn, steps_reg <= PW'(PROBE_DEPTH), "probe overrun")
endmodule
`default_nettype wire
